### hw/rtl/irb_pkg.sv
// Package for image_resize_box2: default sizes, register indexes and
// configuration reset values. No dependencies.
package irb_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int MAX_HEIGHT     = 1024;

	localparam int PIX_PORT_W = 16;
	localparam int COORD_W    = 11;
	localparam int SIZE_W     = 11;
	localparam int ROW_W      = 10;
	localparam int CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_MODE   = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} cfg_reg_t;

	localparam logic              MODE_HALVE  = 1'b0;
	localparam logic              MODE_DOUBLE = 1'b1;
	localparam logic [SIZE_W-1:0] WIDTH_RST   = 11'd1024;
	localparam logic [SIZE_W-1:0] HEIGHT_RST  = 11'd1024;

endpackage

### hw/rtl/irb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module irb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/image_resize_box2.sv
// image_resize_box2: streaming 2x grayscale resizer (2x2 box halve, replicate double).
// Halve mode takes one pixel per cycle while the output does not stall; double mode
// gives four results per pixel on the single result port and stalls the input while
// they are output. Reset clears counters and left pixel and restores default
// configuration; the line store is not cleared. Depends on irb_pkg and irb_ram.
module image_resize_box2 import irb_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_PORT_W-1:0] pixel_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_PORT_W-1:0] pixel_out,
	output logic [COORD_W-1:0]    out_col,
	output logic [COORD_W-1:0]    out_row,
	output logic                  run_last,
	output logic                  frame_last
);

	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW    = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PB    = PIXEL_BITS;
	localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);
	localparam logic [SIZE_W-1:0] MAX_H = SIZE_W'(MAX_HEIGHT);

	// configuration
	logic              mode_q;
	logic [SIZE_W-1:0] fw_q;
	logic [SIZE_W-1:0] fh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HALVE;
			fw_q   <= WIDTH_RST;
			fh_q   <= HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCALE_MODE:   mode_q <= cfg_data[0];
				REG_FRAME_WIDTH:  fw_q   <= cfg_data;
				REG_FRAME_HEIGHT: fh_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective sizes
	logic [EW-1:0]     fw_e, w_e;
	logic [SIZE_W-1:0] h_e;

	always_comb begin
		fw_e = EW'(fw_q);
		if (fw_q == '0) begin
			w_e = EW'(1);
		end else if (fw_e > MAX_W_E) begin
			w_e = MAX_W_E;
		end else begin
			w_e = fw_e;
		end
		if (fh_q == '0) begin
			h_e = SIZE_W'(1);
		end else if (fh_q > MAX_H) begin
			h_e = MAX_H;
		end else begin
			h_e = fh_q;
		end
	end

	// stage 1
	logic             in_acc;
	logic             adv_s1;
	logic             valid_s1;
	logic             emit_s1;
	logic             single_s1;
	logic             fl_s1;
	logic [PB-1:0]    pix_s1;
	logic [PB-1:0]    left_s1;
	logic [COORD_W-1:0] col_s1, row_s1;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PB-1:0]    left_q;

	logic [EW-1:0]     c_e, c_nx, w_even;
	logic [SIZE_W-1:0] r_e, r_nx, h_even;
	logic [PB-1:0]     pix;
	logic              halve, rd_en, wr_en, emit, single, fl;
	logic [COORD_W-1:0] col_b, row_b;
	logic [AW-1:0]     addr;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = valid_s1 && !adv_s1;

	always_comb begin
		pix    = pixel_in[PB-1:0];
		c_e    = (EW'(col_q) >= w_e) ? '0 : EW'(col_q);
		r_e    = (SIZE_W'(row_q) >= h_e) ? '0 : SIZE_W'(row_q);
		halve  = (mode_q == MODE_HALVE);
		w_even = w_e & ~EW'(1);
		h_even = h_e & ~SIZE_W'(1);
		wr_en  = in_acc && halve && !r_e[0];
		rd_en  = in_acc && halve && r_e[0] && c_e[0];
		addr   = AW'(c_e >> 1);
		single = halve;
		emit   = !halve || (r_e[0] && c_e[0]);
		if (halve) begin
			col_b = COORD_W'(c_e >> 1);
			row_b = COORD_W'(r_e >> 1);
			fl    = (c_e == w_even - EW'(1)) && (r_e == h_even - SIZE_W'(1));
		end else begin
			col_b = COORD_W'(c_e << 1);
			row_b = COORD_W'(r_e << 1);
			fl    = (c_e == w_e - EW'(1)) && (r_e == h_e - SIZE_W'(1));
		end
		c_nx = c_e + EW'(1);
		r_nx = r_e;
		if (c_nx >= w_e) begin
			c_nx = '0;
			r_nx = r_e + SIZE_W'(1);
			if (r_nx >= h_e) begin
				r_nx = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			left_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				col_q    <= CW'(c_nx);
				row_q    <= ROW_W'(r_nx);
				left_q   <= pix;
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			emit_s1   <= emit;
			single_s1 <= single;
			fl_s1     <= fl;
			pix_s1    <= pix;
			left_s1   <= left_q;
			col_s1    <= col_b;
			row_s1    <= row_b;
		end
	end

	// line store, split by column parity
	logic [PB-1:0] even_rd, odd_rd;

	irb_ram #(.WIDTH(PB), .DEPTH(DEPTH), .AW(AW)) u_even (
		.clk     (clk),
		.wr_en   (wr_en && !c_e[0]),
		.wr_addr (addr),
		.wr_data (pix),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (even_rd)
	);

	irb_ram #(.WIDTH(PB), .DEPTH(DEPTH), .AW(AW)) u_odd (
		.clk     (clk),
		.wr_en   (wr_en && c_e[0]),
		.wr_addr (addr),
		.wr_data (pix),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (odd_rd)
	);

	// output stage, one result per cycle while out_stall is low
	logic               ov_q, single_q, fl_q;
	logic [1:0]         phase_q;
	logic [PB-1:0]      opix_q;
	logic [COORD_W-1:0] ocol_q, orow_q;
	logic [PB+1:0]      sum;
	logic               last_ph, out_acc;

	assign sum     = (PB+2)'(even_rd) + (PB+2)'(odd_rd) + (PB+2)'(left_s1) + (PB+2)'(pix_s1);
	assign last_ph = single_q || (phase_q == 2'd3);
	assign out_acc = ov_q && !out_stall;
	assign adv_s1  = !ov_q || (last_ph && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			phase_q <= '0;
		end else begin
			if (valid_s1 && adv_s1) begin
				ov_q    <= emit_s1;
				phase_q <= '0;
			end else if (out_acc) begin
				if (last_ph) begin
					ov_q <= 1'b0;
				end
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			single_q <= single_s1;
			fl_q     <= fl_s1;
			opix_q   <= single_s1 ? sum[PB+1:2] : pix_s1;
			ocol_q   <= col_s1;
			orow_q   <= row_s1;
		end
	end

	assign out_valid  = ov_q;
	assign pixel_out  = PIX_PORT_W'(opix_q);
	assign out_col    = single_q ? ocol_q : (ocol_q | COORD_W'(phase_q[0]));
	assign out_row    = single_q ? orow_q : (orow_q | COORD_W'(phase_q[1]));
	assign run_last   = last_ph;
	assign frame_last = fl_q && last_ph;

endmodule

### tb/tb_image_resize_box2.sv
// Self-checking testbench for image_resize_box2: directed table, then random frames
// in both scale modes under varied idle/stall patterns. Depends on irb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_image_resize_box2 import irb_pkg::*; ();

	localparam int SETTLE_CYCLES = 6;
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RAND_ITEMS    = 230;
	localparam int PRESSURE_PH   = 5;
	localparam int PRELOAD_W     = 64;

	typedef struct packed {
		logic [PIX_PORT_W-1:0] pix;
		logic [COORD_W-1:0]    col;
		logic [COORD_W-1:0]    row;
		logic                  run_end;
		logic                  frame_end;
	} opix_t;

	typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		cfg_reg_t              idx;
		logic [SIZE_W-1:0]     data;
		logic [PIX_PORT_W-1:0] pix;
		logic                  lit;
		opix_t                 want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = REG_SCALE_MODE;
	logic [SIZE_W-1:0]     cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [PIX_PORT_W-1:0] pixel_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [PIX_PORT_W-1:0] pixel_out;
	logic [COORD_W-1:0]    out_col;
	logic [COORD_W-1:0]    out_row;
	logic                  run_last;
	logic                  frame_last;

	// predictor state
	logic                  mode_r = MODE_HALVE;
	logic [SIZE_W-1:0]     width_r = WIDTH_RST;
	logic [SIZE_W-1:0]     height_r = HEIGHT_RST;
	int                    col_pos = 0;
	int                    row_pos = 0;
	logic [PIX_PORT_W-1:0] left_pix = '0;
	logic [PIX_PORT_W-1:0] line_mem [0:MAX_WIDTH_DEF-1];

	opix_t    due_pixels[$];
	dir_row_t dir_tab[$];
	int       err_cnt = 0;
	int       tx_idle_pct = 0;
	int       rx_stall_pct = 0;
	int       hold_reqs = 0;
	int       quiet = 0;

	image_resize_box2 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.out_col   (out_col),
		.out_row   (out_row),
		.run_last  (run_last),
		.frame_last(frame_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int eff_size(input logic [SIZE_W-1:0] v, input int lim);
		if (v == 0) return 1;
		if (v > lim) return lim;
		return int'(v);
	endfunction

	function automatic void resize_pixel(input logic [PIX_PORT_W-1:0] pix);
		int          w, h, c, r;
		logic [17:0] sum;
		opix_t       res;
		w = eff_size(width_r, MAX_WIDTH_DEF);
		h = eff_size(height_r, MAX_HEIGHT);
		if (col_pos >= w) col_pos = 0;
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		if (mode_r == MODE_HALVE) begin
			if (r % 2 == 0) begin
				line_mem[c] = pix;
			end else if (c % 2 == 1) begin
				sum = 18'(line_mem[c-1]) + 18'(line_mem[c]) + 18'(left_pix) + 18'(pix);
				res.pix       = sum[17:2];
				res.col       = COORD_W'(c / 2);
				res.row       = COORD_W'(r / 2);
				res.run_end   = 1'b1;
				res.frame_end = (c == (w / 2) * 2 - 1) && (r == (h / 2) * 2 - 1);
				due_pixels = {due_pixels, res};
			end
		end else begin
			for (int k = 0; k < 4; k++) begin
				res.pix       = pix;
				res.col       = COORD_W'(2 * c + k % 2);
				res.row       = COORD_W'(2 * r + k / 2);
				res.run_end   = (k == 3);
				res.frame_end = (k == 3) && (c == w - 1) && (r == h - 1);
				due_pixels = {due_pixels, res};
			end
		end
		left_pix = pix;
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endfunction

	function automatic void tab_reg(input cfg_reg_t idx, input logic [SIZE_W-1:0] val);
		dir_row_t ent;
		ent = '0;
		ent.kind = ROW_REG;
		ent.idx = idx;
		ent.data = val;
		dir_tab = {dir_tab, ent};
	endfunction

	function automatic void tab_pix(input logic [PIX_PORT_W-1:0] pix);
		dir_row_t ent;
		ent = '0;
		ent.kind = ROW_PIX;
		ent.pix = pix;
		dir_tab = {dir_tab, ent};
	endfunction

	// pixel whose final result is known by inspection
	function automatic void tab_lit(input logic [PIX_PORT_W-1:0] pix,
			input logic [PIX_PORT_W-1:0] pout, input int col, input int row,
			input logic fl);
		dir_row_t ent;
		ent = '0;
		ent.kind = ROW_PIX;
		ent.pix = pix;
		ent.lit = 1'b1;
		ent.want = '{pout, COORD_W'(col), COORD_W'(row), 1'b1, fl};
		dir_tab = {dir_tab, ent};
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(9))
			0: return '0;
			1: return SIZE_W'(MAX_HEIGHT);
			2: return SIZE_W'($urandom_range(MAX_HEIGHT + 1, 2047));
			default: return SIZE_W'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_PORT_W-1:0] pix);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (in_stall);
		resize_pixel(pix);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (due_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [SIZE_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SCALE_MODE:   mode_r = val[0];
			REG_FRAME_WIDTH:  width_r = val;
			REG_FRAME_HEIGHT: height_r = val;
			default: ;
		endcase
	endtask

	// receiver: random stall plus one long hold-off on request
	initial begin : rx_drive
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_out
		opix_t want;
		if (out_valid && !out_stall) begin
			if (due_pixels.size() == 0) begin
				$error("unexpected transaction: pixel_out %h at (%0d,%0d)",
					pixel_out, out_col, out_row);
				err_cnt++;
			end else begin
				want = due_pixels.pop_front();
				if (pixel_out !== want.pix) begin
					$error("pixel_out: expected %h, got %h", want.pix, pixel_out);
					err_cnt++;
				end
				if (out_col !== want.col) begin
					$error("out_col: expected %0d, got %0d", want.col, out_col);
					err_cnt++;
				end
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					err_cnt++;
				end
				if (run_last !== want.run_end) begin
					$error("run_last: expected %b, got %b", want.run_end, run_last);
					err_cnt++;
				end
				if (frame_last !== want.frame_end) begin
					$error("frame_last: expected %b, got %b", want.frame_end, frame_last);
					err_cnt++;
				end
			end
		end
	end

	initial begin : watchdog
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		int                n_rand, ph, batch, we, he, cp, rp;
		logic [SIZE_W-1:0] wv, hv;
		logic              md;
		dir_row_t          ent;

		// row 1 of a 64-wide frame, store primed by the preload row
		tab_pix(16'hFFFF);
		tab_lit(16'hFFFF, 16'hFFFF, 0, 0, 1'b0);
		tab_pix(16'h0000);
		tab_pix(16'h0000);
		// mode switch mid-frame
		tab_reg(REG_SCALE_MODE, SIZE_W'(MODE_DOUBLE));
		tab_lit(16'h0000, 16'h0000, 9, 3, 1'b0);
		// width 0 acts as 1, column clamps to 0
		tab_reg(REG_FRAME_WIDTH, 11'd0);
		tab_lit(16'hA5A5, 16'hA5A5, 1, 3, 1'b0);
		// height 0 acts as 1: 1x1 frame
		tab_reg(REG_FRAME_HEIGHT, 11'd0);
		tab_lit(16'h5A5A, 16'h5A5A, 1, 1, 1'b1);
		tab_lit(16'hFFFF, 16'hFFFF, 1, 1, 1'b1);
		// sizes above the limit clamp
		tab_reg(REG_FRAME_WIDTH, 11'd2047);
		tab_reg(REG_FRAME_HEIGHT, 11'd2047);
		tab_lit(16'h0001, 16'h0001, 1, 1, 1'b0);
		// 3x3 halve: odd trailing column and row dropped
		tab_reg(REG_SCALE_MODE, SIZE_W'(MODE_HALVE));
		tab_reg(REG_FRAME_WIDTH, 11'd3);
		tab_reg(REG_FRAME_HEIGHT, 11'd3);
		tab_pix(16'hFFFF);
		tab_pix(16'h1234);
		tab_pix(16'hFFFF);
		tab_lit(16'hFFFF, 16'hFFFF, 0, 0, 1'b1);
		tab_pix(16'h0000);
		tab_pix(16'h8000);
		tab_pix(16'h7FFF);
		tab_pix(16'h0000);
		// halve with width 1, then height 1: no output
		tab_reg(REG_FRAME_WIDTH, 11'd1);
		tab_reg(REG_FRAME_HEIGHT, 11'd2);
		tab_pix(16'h4321);
		tab_pix(16'hBCDE);
		tab_reg(REG_FRAME_WIDTH, 11'd2);
		tab_reg(REG_FRAME_HEIGHT, 11'd1);
		tab_pix(16'hC3C3);
		tab_pix(16'h3C3C);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// preload: full row 0 of a 64-wide frame fills the low store entries
		write_reg(REG_FRAME_WIDTH, SIZE_W'(PRELOAD_W));
		for (int i = 0; i < PRELOAD_W; i++)
			send_pixel(i < 2 ? 16'hFFFF : PIX_PORT_W'($urandom));

		foreach (dir_tab[i]) begin
			ent = dir_tab[i];
			if (ent.kind == ROW_REG) begin
				write_reg(ent.idx, ent.data);
			end else begin
				send_pixel(ent.pix);
				if (ent.lit)
					due_pixels[due_pixels.size() - 1] = ent.want;
			end
		end

		n_rand = 0;
		ph = 0;
		while (n_rand < RAND_ITEMS) begin
			case (ph % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 69;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 69;
				end
				default: begin
					tx_idle_pct = 16;
					rx_stall_pct = 16;
				end
			endcase
			md = 1'($urandom_range(1));
			wv = pick_size();
			hv = pick_size();
			if (ph == PRESSURE_PH) begin
				md = MODE_DOUBLE;
				wv = 11'd8;
				hv = 11'd4;
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			write_reg(REG_SCALE_MODE, SIZE_W'(md));
			write_reg(REG_FRAME_WIDTH, wv);
			write_reg(REG_FRAME_HEIGHT, hv);
			we = eff_size(wv, MAX_WIDTH_DEF);
			he = eff_size(hv, MAX_HEIGHT);
			cp = (col_pos >= we) ? 0 : col_pos;
			rp = (row_pos >= he) ? 0 : row_pos;
			// mostly finish the frame in progress, sometimes one more whole frame
			if (we * he <= 48 && $urandom_range(3) != 0)
				batch = we * he - (rp * we + cp) + int'($urandom_range(1)) * we * he;
			else
				batch = $urandom_range(1, 24);
			// wide frames stay within the preloaded columns
			if (we > PRELOAD_W && cp + batch > PRELOAD_W)
				batch = PRELOAD_W - cp;
			if (ph == PRESSURE_PH) begin
				batch = 32;
				hold_reqs <= hold_reqs + 1;
			end
			repeat (batch) send_pixel(PIX_PORT_W'($urandom));
			n_rand += batch;
			ph++;
		end

		wait_idle();
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
